[sv/imhvq_pkg.sv]
package imhvq_pkg;

    localparam int ID_W     = 8;
    localparam int ID_DEPTH = 256;

    typedef enum logic [2:0] {
        FN_INSERT   = 3'd0,
        FN_UNDELETE = 3'd1,
        FN_UPVOTE   = 3'd2,
        FN_DOWNVOTE = 3'd3,
        FN_DELETE   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_NOT_PRESENT = 2'd2,
        ST_NOT_ELIG    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ID_NEVER   = 2'd0,
        ID_PRESENT = 2'd1,
        ID_DELETED = 2'd2
    } id_state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  item_id;
        logic [15:0] new_rating;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        top_valid;
        logic [7:0]  top_id;
        logic [15:0] top_rating;
        logic [8:0]  entry_count;
    } out_item_t;

endpackage

[sv/imhvq_ram.sv]
module imhvq_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 24
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/imhvq_id_table.sv]
module imhvq_id_table #(
    parameter int DW = 26
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [imhvq_pkg::ID_W-1:0] wr_addr,
    input  logic [DW-1:0]              wr_data,
    input  logic                       rd_en,
    input  logic [imhvq_pkg::ID_W-1:0] rd_addr,
    output logic [DW-1:0]              rd_data
);

    import imhvq_pkg::*;

    logic [DW-1:0]       mem [ID_DEPTH];
    logic [DW-1:0]       rd_data_reg;
    logic [ID_DEPTH-1:0] valid_reg;
    logic                rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[sv/indexed_max_heap_vote_queue_core.sv]
// Addressable max-heap vote queue. Each beat on s_ carries one operation
// (insert, undelete, upvote, downvote, delete) and yields exactly one beat on
// m_ with the status, the root entry and the entry count. Heap entries and the
// per-id table live in two single-port-read RAMs with registered reads;
// one operation is in flight at a time. A rejected operation or an unused
// code goes straight to reading the root for the result; an accepted one
// may first sift its entry up or down over L levels (L at most
// log2(MAX_ITEMS)), each level costing one or two heap RAM reads plus a
// compare and write-back.
// The id table is cleared by reset at once; no clearing pass is needed.
module indexed_max_heap_vote_queue_core #(
    parameter int MAX_ITEMS   = 256,
    parameter int RATING_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  imhvq_pkg::in_item_t   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output imhvq_pkg::out_item_t  m_payload
);

    import imhvq_pkg::*;

    localparam int RB    = RATING_BITS;
    localparam int POS_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CH_W  = POS_W + 2;
    localparam int HW    = ID_W + RB;
    localparam int IDW   = 2 + POS_W + RB;
    localparam logic [RB-1:0]    RATING_MAX = {RB{1'b1}};
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(MAX_ITEMS);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_ID_WAIT  = 12'b0000_0000_0010,
        S_HP_WAIT  = 12'b0000_0000_0100,
        S_DEL_WAIT = 12'b0000_0000_1000,
        S_UP       = 12'b0000_0001_0000,
        S_UP_WAIT  = 12'b0000_0010_0000,
        S_DN       = 12'b0000_0100_0000,
        S_DN_L     = 12'b0000_1000_0000,
        S_DN_R     = 12'b0001_0000_0000,
        S_WR_CUR   = 12'b0010_0000_0000,
        S_TOP_RD   = 12'b0100_0000_0000,
        S_OUT      = 12'b1000_0000_0000
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [2:0]        func_reg, func_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [RB-1:0]     nr_reg, nr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  cur_pos_reg, cur_pos_next;
    logic [ID_W-1:0]   cur_id_reg, cur_id_next;
    logic [RB-1:0]     cur_rt_reg, cur_rt_next;
    logic [RB-1:0]     gone_reg, gone_next;
    logic [ID_W-1:0]   left_id_reg, left_id_next;
    logic [RB-1:0]     left_rt_reg, left_rt_next;
    status_t           status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_payload_reg, m_payload_next;

    logic              hp_rd_en, hp_wr_en;
    logic [POS_W-1:0]  hp_rd_addr, hp_wr_addr;
    logic [HW-1:0]     hp_wr_data, hp_rdata;
    logic              id_rd_en, id_wr_en;
    logic [ID_W-1:0]   id_wr_addr;
    logic [IDW-1:0]    id_wr_data, id_rdata;

    logic [ID_W-1:0]   hp_rd_id;
    logic [RB-1:0]     hp_rd_rt;
    id_state_t         id_rd_st;
    logic [POS_W-1:0]  id_rd_pos;
    logic [RB-1:0]     id_rd_saved;
    logic [POS_W-1:0]  par_pos;
    logic [CH_W-1:0]   lc_w, rc_w, cnt_w;
    logic [CNT_W-1:0]  last_cnt;
    logic [ID_W-1:0]   cand_id;
    logic [RB-1:0]     cand_rt;
    logic [POS_W-1:0]  cand_pos;
    logic              dn_decide;

    imhvq_ram #(
        .DEPTH (MAX_ITEMS),
        .AW    (POS_W),
        .DW    (HW)
    ) u_heap (
        .aclk    (aclk),
        .wr_en   (hp_wr_en),
        .wr_addr (hp_wr_addr),
        .wr_data (hp_wr_data),
        .rd_en   (hp_rd_en),
        .rd_addr (hp_rd_addr),
        .rd_data (hp_rdata)
    );

    imhvq_id_table #(
        .DW (IDW)
    ) u_ids (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (id_wr_en),
        .wr_addr (id_wr_addr),
        .wr_data (id_wr_data),
        .rd_en   (id_rd_en),
        .rd_addr (s_payload.item_id),
        .rd_data (id_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign id_rd_en  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign hp_rd_id    = hp_rdata[HW-1:RB];
    assign hp_rd_rt    = hp_rdata[RB-1:0];
    assign id_rd_st    = id_state_t'(id_rdata[IDW-1:IDW-2]);
    assign id_rd_pos   = id_rdata[RB+POS_W-1:RB];
    assign id_rd_saved = id_rdata[RB-1:0];
    assign par_pos     = POS_W'((cur_pos_reg - POS_W'(1)) >> 1);
    assign lc_w        = CH_W'({cur_pos_reg, 1'b1});
    assign rc_w        = lc_w + CH_W'(1);
    assign cnt_w       = CH_W'(cnt_reg);
    assign last_cnt    = cnt_reg - CNT_W'(1);

    always_comb begin
        cand_id   = hp_rd_id;
        cand_rt   = hp_rd_rt;
        cand_pos  = lc_w[POS_W-1:0];
        dn_decide = 1'b0;
        if (state_reg == S_DN_R) begin
            dn_decide = 1'b1;
            if (hp_rd_rt > left_rt_reg) begin
                cand_pos = rc_w[POS_W-1:0];
            end else begin
                cand_id = left_id_reg;
                cand_rt = left_rt_reg;
            end
        end else if (state_reg == S_DN_L && rc_w >= cnt_w) begin
            dn_decide = 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        nr_next        = nr_reg;
        cnt_next       = cnt_reg;
        cur_pos_next   = cur_pos_reg;
        cur_id_next    = cur_id_reg;
        cur_rt_next    = cur_rt_reg;
        gone_next      = gone_reg;
        left_id_next   = left_id_reg;
        left_rt_next   = left_rt_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        hp_rd_en       = 1'b0;
        hp_rd_addr     = '0;
        hp_wr_en       = 1'b0;
        hp_wr_addr     = cur_pos_reg;
        hp_wr_data     = {cur_id_reg, cur_rt_reg};
        id_wr_en       = 1'b0;
        id_wr_addr     = cur_id_reg;
        id_wr_data     = {ID_PRESENT, cur_pos_reg, cur_rt_reg};

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next   = s_payload.func;
                    id_next     = s_payload.item_id;
                    nr_next     = RB'(s_payload.new_rating);
                    status_next = ST_OK;
                    state_next  = S_ID_WAIT;
                end
            end
            S_ID_WAIT: begin
                state_next = S_TOP_RD;
                case (func_reg)
                    FN_INSERT, FN_UNDELETE: begin
                        if (id_rd_st != ((func_reg == FN_INSERT) ? ID_NEVER : ID_DELETED)) begin
                            status_next = ST_NOT_ELIG;
                        end else if (cnt_reg >= CNT_FULL) begin
                            status_next = ST_FULL;
                        end else begin
                            cur_pos_next = cnt_reg[POS_W-1:0];
                            cur_id_next  = id_reg;
                            cur_rt_next  = (func_reg == FN_INSERT) ? nr_reg : id_rd_saved;
                            cnt_next     = cnt_reg + CNT_W'(1);
                            state_next   = S_UP;
                        end
                    end
                    FN_UPVOTE, FN_DOWNVOTE, FN_DELETE: begin
                        if (id_rd_st != ID_PRESENT || CNT_W'(id_rd_pos) >= cnt_reg) begin
                            status_next = ST_NOT_PRESENT;
                        end else begin
                            hp_rd_en     = 1'b1;
                            hp_rd_addr   = id_rd_pos;
                            cur_pos_next = id_rd_pos;
                            state_next   = S_HP_WAIT;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_HP_WAIT: begin
                cur_id_next = hp_rd_id;
                state_next  = S_TOP_RD;
                case (func_reg)
                    FN_UPVOTE: begin
                        if (hp_rd_rt != RATING_MAX) begin
                            cur_rt_next = hp_rd_rt + RB'(1);
                            state_next  = S_UP;
                        end
                    end
                    FN_DOWNVOTE: begin
                        if (hp_rd_rt != '0) begin
                            cur_rt_next = hp_rd_rt - RB'(1);
                            state_next  = S_DN;
                        end
                    end
                    default: begin
                        id_wr_en   = 1'b1;
                        id_wr_addr = id_reg;
                        id_wr_data = {ID_DELETED, cur_pos_reg, hp_rd_rt};
                        gone_next  = hp_rd_rt;
                        cnt_next   = last_cnt;
                        if (CNT_W'(cur_pos_reg) != last_cnt) begin
                            hp_rd_en   = 1'b1;
                            hp_rd_addr = last_cnt[POS_W-1:0];
                            state_next = S_DEL_WAIT;
                        end
                    end
                endcase
            end
            S_DEL_WAIT: begin
                cur_id_next = hp_rd_id;
                cur_rt_next = hp_rd_rt;
                state_next  = (hp_rd_rt > gone_reg) ? S_UP : S_DN;
            end
            S_UP: begin
                if (cur_pos_reg == '0) begin
                    state_next = S_WR_CUR;
                end else begin
                    hp_rd_en   = 1'b1;
                    hp_rd_addr = par_pos;
                    state_next = S_UP_WAIT;
                end
            end
            S_UP_WAIT: begin
                if (hp_rd_rt >= cur_rt_reg) begin
                    state_next = S_WR_CUR;
                end else begin
                    hp_wr_en     = 1'b1;
                    hp_wr_data   = hp_rdata;
                    id_wr_en     = 1'b1;
                    id_wr_addr   = hp_rd_id;
                    cur_pos_next = par_pos;
                    state_next   = S_UP;
                end
            end
            S_DN: begin
                if (lc_w >= cnt_w) begin
                    state_next = S_WR_CUR;
                end else begin
                    hp_rd_en   = 1'b1;
                    hp_rd_addr = lc_w[POS_W-1:0];
                    state_next = S_DN_L;
                end
            end
            S_DN_L, S_DN_R: begin
                if (!dn_decide) begin
                    left_id_next = hp_rd_id;
                    left_rt_next = hp_rd_rt;
                    hp_rd_en     = 1'b1;
                    hp_rd_addr   = rc_w[POS_W-1:0];
                    state_next   = S_DN_R;
                end else if (cand_rt <= cur_rt_reg) begin
                    state_next = S_WR_CUR;
                end else begin
                    hp_wr_en     = 1'b1;
                    hp_wr_data   = {cand_id, cand_rt};
                    id_wr_en     = 1'b1;
                    id_wr_addr   = cand_id;
                    cur_pos_next = cand_pos;
                    state_next   = S_DN;
                end
            end
            S_WR_CUR: begin
                hp_wr_en   = 1'b1;
                id_wr_en   = 1'b1;
                state_next = S_TOP_RD;
            end
            S_TOP_RD: begin
                hp_rd_en   = 1'b1;
                hp_rd_addr = '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_payload_next.status      = status_reg;
                    m_payload_next.top_valid   = (cnt_reg != '0);
                    m_payload_next.top_id      = (cnt_reg != '0) ? hp_rd_id : '0;
                    m_payload_next.top_rating  = (cnt_reg != '0) ? 16'(hp_rd_rt) : '0;
                    m_payload_next.entry_count = 9'(cnt_reg);
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        id_reg        <= id_next;
        nr_reg        <= nr_next;
        cur_pos_reg   <= cur_pos_next;
        cur_id_reg    <= cur_id_next;
        cur_rt_reg    <= cur_rt_next;
        gone_reg      <= gone_next;
        left_id_reg   <= left_id_next;
        left_rt_reg   <= left_rt_next;
        status_reg    <= status_next;
        m_payload_reg <= m_payload_next;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("entry count beyond capacity");

    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_ID_WAIT)
        else $error("accepted beat not followed by id lookup");

    a_up_root: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_UP_WAIT |-> cur_pos_reg != '0)
        else $error("sift up compares above the root");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && (!m_valid_reg || m_ready) |=> m_valid_reg)
        else $error("result beat not loaded");
`endif

endmodule

[tb/sv/tb_indexed_max_heap_vote_queue_core.sv]
module tb_indexed_max_heap_vote_queue_core;
    import imhvq_pkg::*;

    localparam int CAP     = 256;
    localparam int RMAX    = 65535;

    class vote_heap_scoreboard;
        logic [7:0]  hid [CAP];
        logic [15:0] hrat [CAP];
        int          cnt;
        int          pos_of [256];
        id_state_t   idst [256];
        logic [15:0] saved [256];
        out_item_t   pending [$];
        int          errors;

        function void clear();
            cnt = 0;
            errors = 0;
            pending.delete();
            foreach (idst[i]) idst[i] = ID_NEVER;
        endfunction

        function void swap_at(int a, int b);
            logic [7:0]  ti;
            logic [15:0] tr;
            ti = hid[a];
            tr = hrat[a];
            hid[a] = hid[b];
            hrat[a] = hrat[b];
            hid[b] = ti;
            hrat[b] = tr;
            pos_of[hid[a]] = a;
            pos_of[hid[b]] = b;
        endfunction

        function void climb(int p);
            int par;
            while (p > 0) begin
                par = (p - 1) / 2;
                if (hrat[par] >= hrat[p]) return;
                swap_at(par, p);
                p = par;
            end
        endfunction

        function void sink(int p);
            int lc;
            int m;
            while (1) begin
                lc = 2 * p + 1;
                if (lc >= cnt) return;
                m = lc;
                if (lc + 1 < cnt && hrat[lc + 1] > hrat[lc]) m = lc + 1;
                if (hrat[m] <= hrat[p]) return;
                swap_at(m, p);
                p = m;
            end
        endfunction

        function void note_op(in_item_t op);
            out_item_t r;
            int p;
            int last;
            logic [15:0] gone;
            r = '0;
            r.status = ST_OK;
            if (op.func == FN_INSERT || op.func == FN_UNDELETE) begin
                if (idst[op.item_id] != (op.func == FN_INSERT ? ID_NEVER : ID_DELETED))
                    r.status = ST_NOT_ELIG;
                else if (cnt >= CAP)
                    r.status = ST_FULL;
                else begin
                    hid[cnt] = op.item_id;
                    hrat[cnt] = (op.func == FN_INSERT) ? op.new_rating : saved[op.item_id];
                    pos_of[op.item_id] = cnt;
                    idst[op.item_id] = ID_PRESENT;
                    cnt++;
                    climb(cnt - 1);
                end
            end else if (op.func inside {FN_UPVOTE, FN_DOWNVOTE, FN_DELETE}) begin
                if (idst[op.item_id] != ID_PRESENT) begin
                    r.status = ST_NOT_PRESENT;
                end else begin
                    p = pos_of[op.item_id];
                    if (op.func == FN_UPVOTE) begin
                        if (hrat[p] != RMAX) begin
                            hrat[p]++;
                            climb(p);
                        end
                    end else if (op.func == FN_DOWNVOTE) begin
                        if (hrat[p] != 0) begin
                            hrat[p]--;
                            sink(p);
                        end
                    end else begin
                        gone = hrat[p];
                        last = cnt - 1;
                        saved[op.item_id] = gone;
                        idst[op.item_id] = ID_DELETED;
                        cnt = last;
                        if (p != last) begin
                            hid[p] = hid[last];
                            hrat[p] = hrat[last];
                            pos_of[hid[p]] = p;
                            if (hrat[p] > gone) climb(p);
                            else sink(p);
                        end
                    end
                end
            end
            if (cnt > 0) begin
                r.top_valid = 1'b1;
                r.top_id = hid[0];
                r.top_rating = hrat[0];
            end
            r.entry_count = cnt[8:0];
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                $display("%0t status exp %0d got %0d", $time, e.status, got.status);
            if (got.top_valid !== e.top_valid)
                $display("%0t top_valid exp %0d got %0d", $time, e.top_valid, got.top_valid);
            if (got.top_id !== e.top_id)
                $display("%0t top_id exp %0d got %0d", $time, e.top_id, got.top_id);
            if (got.top_rating !== e.top_rating)
                $display("%0t top_rating exp %0d got %0d", $time, e.top_rating, got.top_rating);
            if (got.entry_count !== e.entry_count)
                $display("%0t entry_count exp %0d got %0d", $time, e.entry_count,
                         got.entry_count);
            if (got !== e) errors++;
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    int src_idle = 28;
    int dst_idle = 56;
    bit hold_rx = 1'b0;
    bit done = 1'b0;
    vote_heap_scoreboard board;

    always #10 aclk = ~aclk;

    indexed_max_heap_vote_queue_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    task automatic send_op(logic [2:0] f, logic [7:0] id, logic [15:0] rt);
        in_item_t op;
        @(posedge aclk);
        while ($urandom_range(99) < src_idle) @(posedge aclk);
        op.func = f;
        op.item_id = id;
        op.new_rating = rt;
        s_valid <= 1'b1;
        s_payload <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_op(op);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_id(int span);
        return 8'($urandom_range(span - 1));
    endfunction

    task automatic random_phase(int n, int span);
        int k;
        logic [2:0] f;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 30) f = FN_INSERT;
            else if (k < 40) f = FN_UNDELETE;
            else if (k < 62) f = FN_UPVOTE;
            else if (k < 82) f = FN_DOWNVOTE;
            else if (k < 97) f = FN_DELETE;
            else f = 3'($urandom_range(5, 7));
            send_op(f, pick_id(span), ($urandom_range(3) == 0) ?
                    16'($urandom_range(RMAX - 2, RMAX)) : 16'($urandom));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_payload);
        m_ready <= !hold_rx && ($urandom_range(99) >= dst_idle);
    end

    initial begin
        board = new();
        board.clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_op(FN_UPVOTE, 8'd5, 16'd0);
        send_op(FN_DELETE, 8'd5, 16'd0);
        send_op(FN_UNDELETE, 8'd5, 16'd0);
        send_op(FN_INSERT, 8'd0, 16'hFFFF);
        send_op(FN_INSERT, 8'd255, 16'd0);
        send_op(FN_INSERT, 8'd0, 16'd7);
        send_op(FN_UPVOTE, 8'd0, 16'd0);
        send_op(FN_DOWNVOTE, 8'd255, 16'd0);
        send_op(FN_INSERT, 8'd17, 16'hFFFF);
        send_op(FN_DOWNVOTE, 8'd0, 16'd0);
        send_op(FN_DELETE, 8'd0, 16'd0);
        send_op(FN_INSERT, 8'd0, 16'd1);
        send_op(FN_UNDELETE, 8'd17, 16'd0);
        send_op(FN_UNDELETE, 8'd0, 16'd0);
        send_op(3'd5, 8'hAA, 16'h5555);
        send_op(3'd6, 8'h55, 16'hAAAA);
        send_op(3'd7, 8'd1, 16'd1);
        send_op(FN_DELETE, 8'd255, 16'd0);
        send_op(FN_DELETE, 8'd17, 16'd0);
        send_op(FN_DELETE, 8'd0, 16'd0);
        drain();

        // fill to capacity, then undelete an id that is present (not eligible)
        for (int i = 0; i < CAP; i++) begin
            if (board.idst[i] == ID_NEVER)
                send_op(FN_INSERT, 8'(i), 16'($urandom_range(20)));
            else if (board.idst[i] == ID_DELETED)
                send_op(FN_UNDELETE, 8'(i), 16'd0);
        end
        send_op(FN_UNDELETE, 8'd0, 16'd0);
        drain();
        for (int i = 0; i < 256; i++) send_op(FN_DELETE, 8'(i), 16'd0);
        drain();

        random_phase(170, 24);
        drain();
        src_idle = 56;
        dst_idle = 28;
        random_phase(170, 64);
        src_idle = 0;
        dst_idle = 0;
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge aclk);
                hold_rx = 1'b0;
            end
            random_phase(30, 64);
        join
        drain();
        random_phase(150, 256);
        drain();

        repeat (100) @(posedge aclk);
        done = 1'b1;
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20000000;
        if (!done) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
